>>> hw/rtl/bfra_pkg.sv
// bfra_pkg: shared types and constants of the best-fit range allocator
// used by the allocator top level and its remainder unit
`timescale 1ns / 1ps

package bfra_pkg;

   // fixed field widths of the request, response and register port
   localparam int FIELD_BITS       = 32;
   localparam int ALIGN_BITS       = 17;
   localparam int STATUS_BITS      = 2;
   localparam int RANGE_COUNT_BITS = 7;
   localparam int PADDR_BITS       = 3;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 2'd2;

   // register index of pool_size (word address)
   localparam logic REG_POOL_SIZE = 1'b0;

   // sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_MOD_WAIT,
      ST_DECIDE,
      ST_WR_UPD,
      ST_RD_LAST,
      ST_WR_DROP,
      ST_WR_APP,
      ST_FINISH
   } alloc_state_type;

endpackage

>>> hw/rtl/bfra_ram.sv
// bfra_ram: generic single write port, single read port memory
// read data is registered; no dependencies
`timescale 1ns / 1ps

module bfra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/bfra_mod_unit.sv
// bfra_mod_unit: multi-cycle remainder of a value by the alignment
// four quotient bits per cycle; depends on bfra_pkg
`timescale 1ns / 1ps

module bfra_mod_unit #(
   parameter int VAL_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [VAL_BITS-1:0]             dividend,
   input  logic [bfra_pkg::ALIGN_BITS-1:0] divisor,
   output logic                            done,
   output logic [bfra_pkg::ALIGN_BITS-1:0] remainder
);
   import bfra_pkg::*;

   localparam int DIGIT_BITS = 4;
   localparam int STEPS      = (VAL_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PAD_BITS   = STEPS * DIGIT_BITS;
   localparam int CNT_BITS   = $clog2(STEPS + 1);

   logic [PAD_BITS-1:0]   shift_ff, shift_in;
   logic [ALIGN_BITS-1:0] rem_ff, rem_in, rem_step;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   // restoring remainder steps for one digit
   always_comb begin
      logic [ALIGN_BITS:0]   trial;
      logic [ALIGN_BITS-1:0] r;
      r     = rem_ff;
      trial = '0;
      for (int j = 0; j < DIGIT_BITS; j++) begin
         trial = {r, shift_ff[PAD_BITS-1-j]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         r = trial[ALIGN_BITS-1:0];
      end
      rem_step = r;
   end

   // iteration control
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = PAD_BITS'(dividend);
         rem_in   = '0;
         cnt_in   = CNT_BITS'(STEPS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << DIGIT_BITS;
         rem_in   = rem_step;
         cnt_in   = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/best_fit_range_allocator_unit.sv
// best_fit_range_allocator_unit: best-fit free range allocator, top level
// depends on bfra_pkg, bfra_ram and bfra_mod_unit
`timescale 1ns / 1ps
//
// Usage
//   Requests come in on req_* (valid/stall). req_op 0 allocates req_count
//   elements aligned to req_alignment (zero counts as one); req_op 1 frees
//   req_count elements at req_first. Every request gives one response on
//   rsp_* with a status, the aligned offset and the number of free ranges.
//   The free range table lives in one memory of MAX_RANGES words; the block
//   handles one request at a time and walks the table one entry per visit.
//   Each visited table entry takes a read and an evaluation state; an entry
//   whose padding is computed (alignment above one) also waits for the
//   remainder unit, and table writes follow the scan. The block returns to
//   idle between requests and takes no new request during a scan or its
//   table writes; the remainder unit and the single memory read port set the pace.
//   Writing pool_size through the APB port resets the table to one range.
//   After reset the block writes table entry 0 in its init state and holds
//   req_stall high meanwhile. The response sits in an output register; a
//   stalled response holds, and the next request may already be accepted
//   and processed; it waits only for the output register to free up.

module best_fit_range_allocator_unit #(
   parameter int MAX_RANGES  = 64,
   parameter int OFFSET_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [bfra_pkg::FIELD_BITS-1:0]       req_count,
   input  logic [bfra_pkg::ALIGN_BITS-1:0]       req_alignment,
   input  logic [bfra_pkg::FIELD_BITS-1:0]       req_first,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bfra_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [bfra_pkg::FIELD_BITS-1:0]       rsp_offset,
   output logic [bfra_pkg::RANGE_COUNT_BITS-1:0] rsp_free_ranges,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [bfra_pkg::PADDR_BITS-1:0]       paddr,
   input  logic [bfra_pkg::FIELD_BITS-1:0]       pwdata,
   output logic [bfra_pkg::FIELD_BITS-1:0]       prdata,
   output logic                                  pready
);
   import bfra_pkg::*;

   localparam int VW = OFFSET_BITS;
   localparam int AW = $clog2(MAX_RANGES);
   localparam int TW = $clog2(MAX_RANGES + 1);
   localparam int EW = ((VW > ALIGN_BITS) ? VW : ALIGN_BITS) + 1;
   localparam int MW = 2 * VW;
   localparam logic [FIELD_BITS-1:0] POOL_SIZE_RESET = 32'd65536;

   function automatic logic [VW-1:0] to_val(input logic [FIELD_BITS-1:0] x);
      logic [VW+FIELD_BITS-1:0] t;
      t = {{VW{1'b0}}, x};
      return t[VW-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(input logic [VW-1:0] x);
      logic [VW+FIELD_BITS-1:0] t;
      t = {{FIELD_BITS{1'b0}}, x};
      return t[FIELD_BITS-1:0];
   endfunction

   alloc_state_type state_ff, state_in;

   logic [FIELD_BITS-1:0]  pool_size_ff, pool_size_in;
   logic [TW-1:0]          total_ff, total_in;
   logic [TW-1:0]          idx_ff, idx_in;
   logic                   op_ff, op_in;
   logic [VW-1:0]          cnt_ff, cnt_in;
   logic [ALIGN_BITS-1:0]  align_ff, align_in;
   logic [VW-1:0]          first_ff, first_in;
   logic [VW-1:0]          after_ff, after_in;
   logic                   found_ff, found_in;
   logic [AW-1:0]          best_ff, best_in;
   logic [ALIGN_BITS-1:0]  best_pad_ff, best_pad_in;
   logic [VW-1:0]          best_start_ff, best_start_in;
   logic [VW-1:0]          best_len_ff, best_len_in;
   logic                   has_prev_ff, has_prev_in;
   logic                   has_next_ff, has_next_in;
   logic [AW-1:0]          prev_ff, prev_in;
   logic [AW-1:0]          next_ff, next_in;
   logic [VW-1:0]          prev_start_ff, prev_start_in;
   logic [VW-1:0]          prev_len_ff, prev_len_in;
   logic [VW-1:0]          next_start_ff, next_start_in;
   logic [VW-1:0]          next_len_ff, next_len_in;
   logic [AW-1:0]          upd_addr_ff, upd_addr_in;
   logic [MW-1:0]          upd_word_ff, upd_word_in;
   logic [AW-1:0]          drop_dst_ff, drop_dst_in;
   logic [MW-1:0]          app_word_ff, app_word_in;
   logic                   do_drop_ff, do_drop_in;
   logic                   do_app_ff, do_app_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [VW-1:0]          res_offset_ff, res_offset_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [FIELD_BITS-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [RANGE_COUNT_BITS-1:0] rsp_free_ranges_ff, rsp_free_ranges_in;

   // memory and remainder unit hookup
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [MW-1:0]         ram_wdata, rd_word;
   logic [VW-1:0]         rd_start, rd_len, rd_end;
   logic                  mod_start, mod_done;
   logic [ALIGN_BITS-1:0] mod_rem;

   // handshake and scan helpers
   logic                  accept, cfg_wr, rsp_load;
   logic [TW-1:0]         idx_next, last_entry_idx;
   logic                  last_entry;
   logic [ALIGN_BITS-1:0] pad_cur;
   logic                  fits, exact_fit, skip_len, eval_apply;
   logic [EW-1:0]         len_e, padc_e, cnt_e, slack_e;

   // free scan neighbor match
   logic                  f_hp, f_hn, f_stop;
   logic [AW-1:0]         f_prev, f_next;
   logic [VW-1:0]         f_ps, f_pl, f_ns, f_nl;

   // plan made once the scan ends
   logic [EW-1:0]          bpad_e, used_e;
   logic [VW-1:0]          used_v;
   logic                   exact_v, hn_eff, table_full;
   logic                   plan_upd, plan_drop, plan_app;
   logic [STATUS_BITS-1:0] plan_status;
   logic [VW-1:0]          plan_offset;
   logic [AW-1:0]          plan_upd_addr, plan_drop_dst;
   logic [MW-1:0]          plan_upd_word, plan_app_word;

   bfra_ram #(
      .WIDTH (MW),
      .DEPTH (MAX_RANGES)
   ) u_range_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rd_word)
   );

   bfra_mod_unit #(
      .VAL_BITS (VW)
   ) u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rd_start),
      .divisor   (align_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rd_start = rd_word[MW-1:VW];
   assign rd_len   = rd_word[VW-1:0];
   assign rd_end   = rd_start + rd_len;

   assign accept   = req_valid && !req_stall;
   assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_SIZE);
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign idx_next       = idx_ff + TW'(1);
   assign last_entry     = (idx_next == total_ff);
   assign last_entry_idx = total_ff - TW'(1);
   assign table_full     = (total_ff >= TW'(MAX_RANGES));

   // alignment padding and fit test for the entry under evaluation
   always_comb begin
      pad_cur = '0;
      if (state_ff == ST_MOD_WAIT && mod_rem != '0) begin
         pad_cur = align_ff - mod_rem;
      end
   end

   assign len_e     = EW'(rd_len);
   assign padc_e    = EW'(pad_cur);
   assign cnt_e     = EW'(cnt_ff);
   assign slack_e   = len_e - padc_e;
   assign fits      = (len_e >= padc_e) && (slack_e >= cnt_e);
   assign exact_fit = fits && (slack_e == cnt_e);
   assign skip_len  = found_ff && (best_len_ff < rd_len);
   assign eval_apply = (op_ff == OP_ALLOC) &&
      (((state_ff == ST_SCAN_EVAL) && !skip_len && (align_ff == ALIGN_BITS'(1))) ||
       ((state_ff == ST_MOD_WAIT) && mod_done));

   // neighbor match for a free request
   always_comb begin
      f_hp   = has_prev_ff;
      f_hn   = has_next_ff;
      f_prev = prev_ff;
      f_next = next_ff;
      f_ps   = prev_start_ff;
      f_pl   = prev_len_ff;
      f_ns   = next_start_ff;
      f_nl   = next_len_ff;
      f_stop = 1'b0;
      if (rd_start == after_ff) begin
         f_hn   = 1'b1;
         f_next = idx_ff[AW-1:0];
         f_ns   = rd_start;
         f_nl   = rd_len;
         if (has_prev_ff) begin
            f_stop = 1'b1;
         end
      end
      if (!f_stop && rd_end == first_ff) begin
         f_hp   = 1'b1;
         f_prev = idx_ff[AW-1:0];
         f_ps   = rd_start;
         f_pl   = rd_len;
         if (f_hn) begin
            f_stop = 1'b1;
         end
      end
   end

   // table update plan
   assign bpad_e  = EW'(best_pad_ff);
   assign used_e  = cnt_e + bpad_e;
   assign used_v  = VW'(used_e);
   assign exact_v = (best_len_ff == used_v);
   assign hn_eff  = has_next_ff && !(has_prev_ff && prev_ff == next_ff);

   always_comb begin
      plan_upd      = 1'b0;
      plan_drop     = 1'b0;
      plan_app      = 1'b0;
      plan_status   = STATUS_OK;
      plan_offset   = '0;
      plan_upd_addr = best_ff;
      plan_upd_word = '0;
      plan_drop_dst = best_ff;
      plan_app_word = '0;
      if (op_ff == OP_ALLOC) begin
         if (!found_ff) begin
            plan_status = STATUS_NO_FIT;
         end else if (best_pad_ff != '0 && !exact_v && table_full) begin
            plan_status = STATUS_FULL;
         end else begin
            plan_offset = VW'(EW'(best_start_ff) + bpad_e);
            if (exact_v) begin
               plan_drop = 1'b1;
            end else begin
               plan_upd      = 1'b1;
               plan_upd_word = {best_start_ff + used_v, best_len_ff - used_v};
            end
            plan_app      = (best_pad_ff != '0);
            plan_app_word = {best_start_ff, VW'(bpad_e)};
         end
      end else begin
         if (!has_prev_ff && !hn_eff) begin
            if (table_full) begin
               plan_status = STATUS_FULL;
            end else begin
               plan_app      = 1'b1;
               plan_app_word = {first_ff, cnt_ff};
            end
         end else if (has_prev_ff && hn_eff) begin
            plan_upd      = 1'b1;
            plan_upd_addr = prev_ff;
            plan_upd_word = {prev_start_ff, prev_len_ff + cnt_ff + next_len_ff};
            plan_drop     = 1'b1;
            plan_drop_dst = next_ff;
         end else if (has_prev_ff) begin
            plan_upd      = 1'b1;
            plan_upd_addr = prev_ff;
            plan_upd_word = {prev_start_ff, prev_len_ff + cnt_ff};
         end else begin
            plan_upd      = 1'b1;
            plan_upd_addr = next_ff;
            plan_upd_word = {next_start_ff - cnt_ff, next_len_ff + cnt_ff};
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (total_ff == '0) ? ST_DECIDE : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            if (op_ff == OP_ALLOC) begin
               if (!skip_len && align_ff != ALIGN_BITS'(1)) begin
                  state_in = ST_MOD_WAIT;
               end else if (eval_apply && exact_fit) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = last_entry ? ST_DECIDE : ST_SCAN_RD;
               end
            end else begin
               state_in = (f_stop || last_entry) ? ST_DECIDE : ST_SCAN_RD;
            end
         end
         ST_MOD_WAIT: begin
            if (mod_done) begin
               if (exact_fit || last_entry) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_DECIDE: begin
            if (plan_upd) begin
               state_in = ST_WR_UPD;
            end else if (plan_drop) begin
               state_in = ST_RD_LAST;
            end else if (plan_app) begin
               state_in = ST_WR_APP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WR_UPD: begin
            if (do_drop_ff) begin
               state_in = ST_RD_LAST;
            end else if (do_app_ff) begin
               state_in = ST_WR_APP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RD_LAST: begin
            state_in = ST_WR_DROP;
         end
         ST_WR_DROP: begin
            state_in = do_app_ff ? ST_WR_APP : ST_FINISH;
         end
         ST_WR_APP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer: memory ports, remainder start, request stall
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mod_start = (state_ff == ST_SCAN_EVAL) && (op_ff == OP_ALLOC) && !skip_len &&
                  (align_ff != ALIGN_BITS'(1));
      ram_raddr = (state_ff == ST_RD_LAST) ? last_entry_idx[AW-1:0] : idx_ff[AW-1:0];
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      if (cfg_wr) begin
         ram_we    = 1'b1;
         ram_wdata = {{VW{1'b0}}, to_val(pwdata)};
      end else begin
         case (state_ff)
            ST_INIT: begin
               ram_we    = 1'b1;
               ram_wdata = {{VW{1'b0}}, to_val(pool_size_ff)};
            end
            ST_WR_UPD: begin
               ram_we    = 1'b1;
               ram_waddr = upd_addr_ff;
               ram_wdata = upd_word_ff;
            end
            ST_WR_DROP: begin
               ram_we    = 1'b1;
               ram_waddr = drop_dst_ff;
               ram_wdata = rd_word;
            end
            ST_WR_APP: begin
               ram_we    = 1'b1;
               ram_waddr = total_ff[AW-1:0];
               ram_wdata = app_word_ff;
            end
            default: begin
               ram_we = 1'b0;
            end
         endcase
      end
   end

   // datapath register next values
   always_comb begin
      pool_size_in       = pool_size_ff;
      total_in           = total_ff;
      idx_in             = idx_ff;
      op_in              = op_ff;
      cnt_in             = cnt_ff;
      align_in           = align_ff;
      first_in           = first_ff;
      after_in           = after_ff;
      found_in           = found_ff;
      best_in            = best_ff;
      best_pad_in        = best_pad_ff;
      best_start_in      = best_start_ff;
      best_len_in        = best_len_ff;
      has_prev_in        = has_prev_ff;
      has_next_in        = has_next_ff;
      prev_in            = prev_ff;
      next_in            = next_ff;
      prev_start_in      = prev_start_ff;
      prev_len_in        = prev_len_ff;
      next_start_in      = next_start_ff;
      next_len_in        = next_len_ff;
      upd_addr_in        = upd_addr_ff;
      upd_word_in        = upd_word_ff;
      drop_dst_in        = drop_dst_ff;
      app_word_in        = app_word_ff;
      do_drop_in         = do_drop_ff;
      do_app_in          = do_app_ff;
      res_status_in      = res_status_ff;
      res_offset_in      = res_offset_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_offset_in      = rsp_offset_ff;
      rsp_free_ranges_in = rsp_free_ranges_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;

      // latch the request
      if (accept) begin
         op_in       = req_op;
         cnt_in      = to_val(req_count);
         align_in    = (req_alignment == '0) ? ALIGN_BITS'(1) : req_alignment;
         first_in    = to_val(req_first);
         after_in    = to_val(req_first) + to_val(req_count);
         idx_in      = '0;
         found_in    = 1'b0;
         has_prev_in = 1'b0;
         has_next_in = 1'b0;
      end

      // best-fit candidate update
      if (eval_apply && fits) begin
         found_in      = 1'b1;
         best_in       = idx_ff[AW-1:0];
         best_pad_in   = pad_cur;
         best_start_in = rd_start;
         best_len_in   = rd_len;
      end

      // neighbor tracking for a free
      if (state_ff == ST_SCAN_EVAL && op_ff == OP_FREE) begin
         has_prev_in   = f_hp;
         has_next_in   = f_hn;
         prev_in       = f_prev;
         next_in       = f_next;
         prev_start_in = f_ps;
         prev_len_in   = f_pl;
         next_start_in = f_ns;
         next_len_in   = f_nl;
      end

      // step to the next entry
      if ((state_ff == ST_SCAN_EVAL || state_ff == ST_MOD_WAIT) && state_in == ST_SCAN_RD) begin
         idx_in = idx_next;
      end

      // commit the plan
      if (state_ff == ST_DECIDE) begin
         res_status_in = plan_status;
         res_offset_in = plan_offset;
         do_drop_in    = plan_drop;
         do_app_in     = plan_app;
         upd_addr_in   = plan_upd_addr;
         upd_word_in   = plan_upd_word;
         drop_dst_in   = plan_drop_dst;
         app_word_in   = plan_app_word;
      end

      // table count follows drops and appends
      if (state_ff == ST_WR_DROP) begin
         total_in = total_ff - TW'(1);
      end
      if (state_ff == ST_WR_APP) begin
         total_in = total_ff + TW'(1);
      end

      // response register
      if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_status_in      = res_status_ff;
         rsp_offset_in      = to_field(res_offset_ff);
         rsp_free_ranges_in = RANGE_COUNT_BITS'(total_ff);
      end

      // pool size write restarts the table
      if (cfg_wr) begin
         pool_size_in = pwdata;
         total_in     = TW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         pool_size_ff <= POOL_SIZE_RESET;
         total_ff     <= TW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_size_ff <= pool_size_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff             <= idx_in;
      op_ff              <= op_in;
      cnt_ff             <= cnt_in;
      align_ff           <= align_in;
      first_ff           <= first_in;
      after_ff           <= after_in;
      found_ff           <= found_in;
      best_ff            <= best_in;
      best_pad_ff        <= best_pad_in;
      best_start_ff      <= best_start_in;
      best_len_ff        <= best_len_in;
      has_prev_ff        <= has_prev_in;
      has_next_ff        <= has_next_in;
      prev_ff            <= prev_in;
      next_ff            <= next_in;
      prev_start_ff      <= prev_start_in;
      prev_len_ff        <= prev_len_in;
      next_start_ff      <= next_start_in;
      next_len_ff        <= next_len_in;
      upd_addr_ff        <= upd_addr_in;
      upd_word_ff        <= upd_word_in;
      drop_dst_ff        <= drop_dst_in;
      app_word_ff        <= app_word_in;
      do_drop_ff         <= do_drop_in;
      do_app_ff          <= do_app_in;
      res_status_ff      <= res_status_in;
      res_offset_ff      <= res_offset_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_offset_ff      <= rsp_offset_in;
      rsp_free_ranges_ff <= rsp_free_ranges_in;
   end

   // port drive
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_offset      = rsp_offset_ff;
   assign rsp_free_ranges = rsp_free_ranges_ff;
   assign pready          = 1'b1;
   assign prdata          = (paddr[2] == REG_POOL_SIZE) ? pool_size_ff : '0;

   // table count never passes its capacity
   assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(MAX_RANGES))
      else $error("free range count exceeds table capacity");

   // remainder results only arrive while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == ST_MOD_WAIT)
      else $error("remainder done outside of wait state");

   // an append never happens on a full table
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR_APP |-> total_ff < TW'(MAX_RANGES))
      else $error("append on full table");

   // a table-full response reports a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |->
         rsp_free_ranges_ff == RANGE_COUNT_BITS'(MAX_RANGES))
      else $error("table full status with free table slots");

endmodule

>>> bench/best_fit_range_allocator_checker.sv
// best_fit_range_allocator_checker: predicts and checks every response of the allocator
// watches the request, response and register ports; depends on bfra_pkg
`timescale 1ns / 1ps

module best_fit_range_allocator_checker #(
   parameter int MAX_RANGES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [bfra_pkg::FIELD_BITS-1:0]       req_count,
   input  logic [bfra_pkg::ALIGN_BITS-1:0]       req_alignment,
   input  logic [bfra_pkg::FIELD_BITS-1:0]       req_first,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [bfra_pkg::STATUS_BITS-1:0]      rsp_status,
   input  logic [bfra_pkg::FIELD_BITS-1:0]       rsp_offset,
   input  logic [bfra_pkg::RANGE_COUNT_BITS-1:0] rsp_free_ranges,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic                                  pready,
   input  logic [bfra_pkg::PADDR_BITS-1:0]       paddr,
   input  logic [bfra_pkg::FIELD_BITS-1:0]       pwdata,
   output int                                    failures,
   output int                                    pending
);
   import bfra_pkg::*;

   typedef struct packed {
      logic [STATUS_BITS-1:0]      status;
      logic [FIELD_BITS-1:0]       offset;
      logic [RANGE_COUNT_BITS-1:0] free_ranges;
   } alloc_result_type;

   // free range table as the block should hold it
   logic [FIELD_BITS-1:0] free_start [MAX_RANGES];
   logic [FIELD_BITS-1:0] free_len   [MAX_RANGES];
   int                    free_total;
   alloc_result_type      result_q [$];

   assign pending = result_q.size();

   function automatic void load_pool(logic [FIELD_BITS-1:0] size);
      for (int i = 0; i < MAX_RANGES; i++) begin
         free_start[i] = '0;
         free_len[i]   = '0;
      end
      free_len[0] = size;
      free_total  = 1;
   endfunction

   function automatic void remove_range(int idx);
      free_start[idx] = free_start[free_total-1];
      free_len[idx]   = free_len[free_total-1];
      free_total--;
   endfunction

   // best fit scan, then shrink or drop and append padding
   function automatic logic [STATUS_BITS-1:0] predict_alloc(logic [FIELD_BITS-1:0] cnt,
         logic [ALIGN_BITS-1:0] align_in, output logic [FIELD_BITS-1:0] off);
      logic [63:0]           align;
      logic [63:0]           len;
      logic [63:0]           pad;
      logic [63:0]           best_pad;
      logic [63:0]           used;
      logic [FIELD_BITS-1:0] orig;
      logic                  found;
      logic                  exact;
      int                    best;
      align    = (align_in == 0) ? 64'd1 : 64'(align_in);
      found    = 1'b0;
      best     = 0;
      best_pad = '0;
      off      = '0;
      for (int i = 0; i < free_total; i++) begin
         len = 64'(free_len[i]);
         pad = 64'(free_start[i]) % align;
         if (found && 64'(free_len[best]) < len) continue;
         if (pad != 0) pad = align - pad;
         if (len < pad || len - pad < 64'(cnt)) continue;
         found    = 1'b1;
         best     = i;
         best_pad = pad;
         if (len - pad == 64'(cnt)) break;
      end
      if (!found) return STATUS_NO_FIT;
      orig  = free_start[best];
      used  = 64'(cnt) + best_pad;
      exact = (64'(free_len[best]) == used);
      if (best_pad != 0 && !exact && free_total >= MAX_RANGES) return STATUS_FULL;
      if (exact) remove_range(best);
      else begin
         free_start[best] = orig + used[FIELD_BITS-1:0];
         free_len[best]   = free_len[best] - used[FIELD_BITS-1:0];
      end
      if (best_pad != 0) begin
         free_start[free_total] = orig;
         free_len[free_total]   = best_pad[FIELD_BITS-1:0];
         free_total++;
      end
      off = orig + best_pad[FIELD_BITS-1:0];
      return STATUS_OK;
   endfunction

   // merge with neighbors or append a new range
   function automatic logic [STATUS_BITS-1:0] predict_free(logic [FIELD_BITS-1:0] fst,
         logic [FIELD_BITS-1:0] cnt);
      logic                  has_prev;
      logic                  has_next;
      int                    prev;
      int                    next;
      logic [FIELD_BITS-1:0] after;
      has_prev = 1'b0;
      has_next = 1'b0;
      prev     = 0;
      next     = 0;
      after    = fst + cnt;
      for (int i = 0; i < free_total; i++) begin
         if (free_start[i] == after) begin
            has_next = 1'b1;
            next     = i;
            if (has_prev) break;
         end
         if (FIELD_BITS'(free_start[i] + free_len[i]) == fst) begin
            has_prev = 1'b1;
            prev     = i;
            if (has_next) break;
         end
      end
      // one range on both sides counts as the previous one only
      if (has_prev && has_next && prev == next) has_next = 1'b0;
      if (!has_prev && !has_next) begin
         if (free_total >= MAX_RANGES) return STATUS_FULL;
         free_start[free_total] = fst;
         free_len[free_total]   = cnt;
         free_total++;
      end else if (has_prev && has_next) begin
         free_len[prev] = free_len[prev] + cnt + free_len[next];
         remove_range(next);
      end else if (has_prev) begin
         free_len[prev] = free_len[prev] + cnt;
      end else begin
         free_start[next] = free_start[next] - cnt;
         free_len[next]   = free_len[next] + cnt;
      end
      return STATUS_OK;
   endfunction

   initial begin
      failures = 0;
      load_pool(32'd65536);
   end

   always @(posedge clock) begin
      alloc_result_type want;
      alloc_result_type got;
      if (reset) begin
         load_pool(32'd65536);
         result_q.delete();
      end else begin
         // register write
         if (psel && penable && pwrite && pready && paddr == PADDR_BITS'(REG_POOL_SIZE))
            load_pool(pwdata);
         // accepted request
         if (req_valid && !req_stall) begin
            want.offset = '0;
            if (req_op == OP_ALLOC)
               want.status = predict_alloc(req_count, req_alignment, want.offset);
            else
               want.status = predict_free(req_first, req_count);
            if (want.status != STATUS_OK) want.offset = '0;
            want.free_ranges = RANGE_COUNT_BITS'(free_total);
            result_q.push_back(want);
         end
         // accepted response
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_offset, rsp_free_ranges};
            if (result_q.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = result_q.pop_front();
               if (got.status != want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  failures++;
               end
               if (got.offset != want.offset) begin
                  $error("offset expected %0h actual %0h", want.offset, got.offset);
                  failures++;
               end
               if (got.free_ranges != want.free_ranges) begin
                  $error("free_ranges expected %0d actual %0d", want.free_ranges,
                         got.free_ranges);
                  failures++;
               end
            end
         end
      end
   end

endmodule

>>> bench/testbench.sv
// testbench: drives requests, register writes and response stalls into the allocator
// depends on bfra_pkg, best_fit_range_allocator_unit and best_fit_range_allocator_checker
`timescale 1ns / 1ps

module testbench;
   import bfra_pkg::*;

   localparam int CYCLE_LIMIT = 5000000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_op;
   logic [FIELD_BITS-1:0]       req_count;
   logic [ALIGN_BITS-1:0]       req_alignment;
   logic [FIELD_BITS-1:0]       req_first;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [STATUS_BITS-1:0]      rsp_status;
   logic [FIELD_BITS-1:0]       rsp_offset;
   logic [RANGE_COUNT_BITS-1:0] rsp_free_ranges;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [PADDR_BITS-1:0]       paddr;
   logic [FIELD_BITS-1:0]       pwdata;
   logic [FIELD_BITS-1:0]       prdata;
   logic                        pready;
   int                          failures;
   int                          pending;
   int                          cycles;

   typedef struct {
      logic [FIELD_BITS-1:0] first;
      logic [FIELD_BITS-1:0] count;
   } block_type;

   // allocs in flight and blocks handed out, used to make well formed frees
   logic [FIELD_BITS:0] inflight_q [$];
   block_type           held_q [$];
   logic [FIELD_BITS-1:0] pool;

   best_fit_range_allocator_unit DUT (.*);

   best_fit_range_allocator_checker checker_inst (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_count, .req_alignment,
      .req_first, .rsp_valid, .rsp_stall, .rsp_status, .rsp_offset, .rsp_free_ranges,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .failures, .pending
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // track handed-out blocks from accepted requests and responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) inflight_q.push_back({req_op, req_count});
         if (rsp_valid && !rsp_stall && inflight_q.size() > 0) begin
            logic [FIELD_BITS:0] item;
            item = inflight_q.pop_front();
            if (item[FIELD_BITS] == OP_ALLOC && rsp_status == STATUS_OK &&
                item[FIELD_BITS-1:0] != 0)
               held_q.push_back('{rsp_offset, item[FIELD_BITS-1:0]});
         end
      end
   end

   // response stalls: random bursts, and one long hold-off to back the block up
   initial begin
      int stall_left;
      int run_left;
      int elapsed;
      stall_left = 0;
      run_left   = 0;
      elapsed    = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         elapsed++;
         if (elapsed == 20000) stall_left = 3000;
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_stall <= 1'b0;
            run_left--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  rsp_stall <= 1'b0;
                  run_left = $urandom_range(0, 30);
               end
               9: begin
                  rsp_stall <= 1'b1;
                  stall_left = $urandom_range(20, 150);
               end
               default: begin
                  rsp_stall <= 1'b1;
                  stall_left = $urandom_range(0, 3);
               end
            endcase
         end
      end
   end

   task automatic send(logic op, logic [FIELD_BITS-1:0] cnt, logic [ALIGN_BITS-1:0] align,
                       logic [FIELD_BITS-1:0] fst);
      int gap;
      req_valid     <= 1'b1;
      req_op        <= op;
      req_count     <= cnt;
      req_alignment <= align;
      req_first     <= fst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // register write once the block has drained
   task automatic set_pool(logic [FIELD_BITS-1:0] size);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_BITS'(REG_POOL_SIZE);
      pwdata  <= size;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      held_q.delete();
      pool = size;
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic [FIELD_BITS-1:0] cnt;
      logic [ALIGN_BITS-1:0] align;
      int                    pick;
      int                    k;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35 && held_q.size() > 0) begin
            // free a block handed out earlier
            k = $urandom_range(0, held_q.size() - 1);
            send(OP_FREE, held_q[k].count, ALIGN_BITS'($urandom), held_q[k].first);
            held_q.delete(k);
         end else if (pick < 90) begin
            case ($urandom_range(0, 9))
               0:       cnt = $urandom;
               1, 2:    cnt = $urandom_range(0, (pool >> 2) + 1);
               default: cnt = $urandom_range(0, 64);
            endcase
            if ($urandom_range(0, 4) == 0) align = ALIGN_BITS'($urandom);
            else align = ALIGN_BITS'(1 << $urandom_range(0, 16));
            send(OP_ALLOC, cnt, align, $urandom);
         end else begin
            // noise: arbitrary free
            send(OP_FREE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40),
                 ALIGN_BITS'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_ALLOC;
      req_count     = '0;
      req_alignment = 17'd1;
      req_first     = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      pool          = 32'd65536;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pool from reset
      send(OP_ALLOC, 32'd0, 17'd0, 32'hFFFF_FFFF);
      send(OP_ALLOC, 32'd100, 17'd1, '0);
      send(OP_ALLOC, 32'd10, 17'h1FFFF, '0);
      send(OP_ALLOC, 32'd5, 17'd64, '0);
      send(OP_ALLOC, 32'hFFFF_FFFF, 17'd1, '0);
      send(OP_FREE, 32'd100, 17'd1, 32'd0);
      send(OP_FREE, 32'd5, 17'd1, 32'd128);
      send(OP_FREE, 32'h20, 17'd1, 32'hFFFF_FFF0);
      send(OP_FREE, 32'd0, 17'd1, 32'd500000);
      send(OP_FREE, 32'd0, 17'd1, 32'd500000);
      send(OP_ALLOC, 32'd0, 17'd1, '0);
      send(OP_ALLOC, 32'd65403, 17'd1, '0);

      // directed: fill the table, overflow on free, then alloc from the full table
      set_pool(32'd200);
      for (int i = 0; i < 64; i++) send(OP_FREE, 32'd1, 17'd1, 32'd1000 + 2 * i);
      send(OP_FREE, 32'd1, 17'd1, 32'd5000);
      send(OP_ALLOC, 32'd3, 17'd7, '0);
      send(OP_ALLOC, 32'd1, 17'd1, '0);

      // random phases over several pool sizes
      set_pool(32'd0);
      random_phase(150);
      set_pool(32'hFFFF_FFFF);
      random_phase(250);
      set_pool(32'd300);
      random_phase(250);
      set_pool(32'd4096);
      random_phase(250);
      set_pool($urandom);
      random_phase(200);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      if (failures == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
